// File: design/rkl_pkg.sv
package rkl_pkg;

	localparam int VALUE_W       = 11;
	localparam int COUNT_W       = 11;
	localparam int K_W           = 11;
	localparam int MAX_VALUE_DEF = 1024;
	localparam int EPOCH_W       = 8;

	// read address select for the seen-map RAM
	localparam logic [1:0] RD_ITEM  = 2'd0;
	localparam logic [1:0] RD_VALUE = 2'd1;
	localparam logic [1:0] RD_WALK  = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       clr_en;
		logic [1:0] rd_sel;
		logic       check;
		logic       walk_step;
		logic       walk_done;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic restart_wrap;
		logic clr_last;
		logic in_range;
		logic seen;
		logic fill;
		logic fill_result;
		logic need_walk;
		logic p_at_v;
		logic out_free;
	} sts_t;

endpackage

// File: design/running_kth_largest_top.sv
// Running k-th largest over a stream of distinct values 1..MAX_VALUE. Each new value
// in range is marked in a seen-map RAM; once k values of the sequence have arrived,
// every further new value yields one result (k-th largest so far, item count).
// Out-of-range and repeated values give no result; restart on an item starts a new
// sequence with that item. Each item is accepted, then looked up in the map. If the
// pointer must move, it probes one map entry at a time (registered RAM read, then
// compare), and it stops when the walk runs up to the new value itself;
// probes are bounded by MAX_VALUE over a whole sequence. A result that finds the
// output register still held waits there, and the input stays closed until it leaves.
// After reset a clearing pass over all MAX_VALUE map entries runs before the first
// item is taken; the same pass runs on every 255th restart, when the per-sequence
// map tag wraps, and that item is looked up once it ends. The user must write k_rank
// only while the block is idle (not enforced here); it takes effect from the next item.
module running_kth_largest_top #(
	parameter int MAX_VALUE = rkl_pkg::MAX_VALUE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        k_rank_we,
	input  logic [rkl_pkg::K_W-1:0]     k_rank,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [rkl_pkg::VALUE_W-1:0] value,
	input  logic                        restart,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [rkl_pkg::VALUE_W-1:0] kth_largest,
	output logic [rkl_pkg::COUNT_W-1:0] items_seen
);
	import rkl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rkl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rkl_dpath #(
		.MAX_VALUE(MAX_VALUE)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.restart     (restart),
		.k_rank_we   (k_rank_we),
		.k_rank      (k_rank),
		.result_ready(result_ready),
		.result_valid(result_valid),
		.kth_largest (kth_largest),
		.items_seen  (items_seen),
		.cmd         (cmd),
		.sts         (sts)
	);

	a_no_item_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_en |-> !item_ready)
		else $error("item taken during map clearing pass");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result register overwritten while still held");

	a_mark_only_new: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check |-> (sts.in_range && !sts.seen))
		else $error("map marked for out-of-range or repeated value");

	a_walk_stays_below_v: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> !sts.p_at_v)
		else $error("pointer walk stepped past the new value");

endmodule

// File: design/rkl_ram.sv
module rkl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/rkl_ctrl.sv
module rkl_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  rkl_pkg::sts_t sts,
	output rkl_pkg::cmd_t cmd
);
	import rkl_pkg::*;

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_LOOKUP   = 3'd2;
	localparam logic [2:0] S_CHECK    = 3'd3;
	localparam logic [2:0] S_WALK_RD  = 3'd4;
	localparam logic [2:0] S_WALK_CHK = 3'd5;
	localparam logic [2:0] S_EMIT     = 3'd6;

	logic [2:0] state_q, state_d;
	logic       from_item_q, from_item_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			from_item_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			from_item_q <= from_item_d;
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.rd_sel  = RD_ITEM;
		item_ready  = 1'b0;
		state_d     = state_q;
		from_item_d = from_item_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d     = from_item_q ? S_LOOKUP : S_IDLE;
					from_item_d = 1'b0;
				end
			end
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (sts.restart_wrap) begin
						// tag space used up: sweep the map, then look the item up
						state_d     = S_CLEAR;
						from_item_d = 1'b1;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_LOOKUP: begin
				cmd.rd_sel = RD_VALUE;
				state_d    = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.in_range || sts.seen) begin
					state_d = S_IDLE;
				end else begin
					cmd.check = 1'b1;
					if (sts.need_walk) begin
						state_d = S_WALK_RD;
					end else if (sts.fill && !sts.fill_result) begin
						state_d = S_IDLE;
					end else if (sts.out_free) begin
						cmd.load_out = 1'b1;
						state_d      = S_IDLE;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_WALK_RD: begin
				cmd.rd_sel = RD_WALK;
				if (sts.p_at_v) begin
					cmd.walk_done = 1'b1;
					if (sts.out_free) begin
						cmd.load_out = 1'b1;
						state_d      = S_IDLE;
					end else begin
						state_d = S_EMIT;
					end
				end else begin
					state_d = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				if (sts.seen) begin
					cmd.walk_done = 1'b1;
					if (sts.out_free) begin
						cmd.load_out = 1'b1;
						state_d      = S_IDLE;
					end else begin
						state_d = S_EMIT;
					end
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = S_WALK_RD;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

// File: design/rkl_dpath.sv
module rkl_dpath #(
	parameter int MAX_VALUE = rkl_pkg::MAX_VALUE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rkl_pkg::VALUE_W-1:0] value,
	input  logic                        restart,
	input  logic                        k_rank_we,
	input  logic [rkl_pkg::K_W-1:0]     k_rank,
	input  logic                        result_ready,
	output logic                        result_valid,
	output logic [rkl_pkg::VALUE_W-1:0] kth_largest,
	output logic [rkl_pkg::COUNT_W-1:0] items_seen,
	input  rkl_pkg::cmd_t               cmd,
	output rkl_pkg::sts_t               sts
);
	import rkl_pkg::*;

	localparam int VW     = $clog2(MAX_VALUE + 1);
	localparam int ADDR_W = $clog2(MAX_VALUE);
	localparam int CMP_W  = (VW > VALUE_W) ? VW : VALUE_W;

	logic [K_W-1:0]     k_rank_q;
	logic [VALUE_W-1:0] v_q;
	logic [VW-1:0]      k_q;
	logic [VW-1:0]      kth_q, kth_d;
	logic [VW-1:0]      count_q, count_d, count_inc;
	logic [VW-1:0]      p_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               result_valid_q;
	logic [VALUE_W-1:0] kth_out_q;
	logic [COUNT_W-1:0] count_out_q;

	logic [CMP_W-1:0]   v_ext, k_ext, item_ext;
	logic [VW-1:0]      v_n, k_eff;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic [EPOCH_W-1:0] wdata, rdata;
	logic               we;

	assign v_ext    = CMP_W'(v_q);
	assign item_ext = CMP_W'(value);
	assign k_ext    = CMP_W'(k_rank_q);
	assign v_n      = VW'(v_q);

	always_comb begin
		if (k_ext == '0) begin
			k_eff = VW'(1);
		end else if (k_ext > CMP_W'(MAX_VALUE)) begin
			k_eff = VW'(MAX_VALUE);
		end else begin
			k_eff = VW'(k_ext);
		end
	end

	assign count_inc = (count_q < VW'(MAX_VALUE)) ? count_q + VW'(1) : count_q;

	assign sts.restart_wrap = restart && (&epoch_q);
	assign sts.clr_last     = clr_addr_q == ADDR_W'(MAX_VALUE - 1);
	assign sts.in_range     = (v_ext != '0) && (v_ext <= CMP_W'(MAX_VALUE));
	assign sts.seen         = rdata == epoch_q;
	assign sts.fill         = count_inc <= k_q;
	assign sts.fill_result  = count_inc == k_q;
	assign sts.need_walk    = (count_inc > k_q) && (v_n > kth_q);
	assign sts.p_at_v       = p_q == v_n;
	assign sts.out_free     = !result_valid_q || result_ready;

	always_comb begin
		kth_d   = kth_q;
		count_d = count_q;
		if (cmd.check) begin
			count_d = count_inc;
			if ((count_inc <= k_q) && ((kth_q == '0) || (v_n < kth_q))) begin
				kth_d = v_n;
			end
		end
		if (cmd.walk_done) begin
			kth_d = p_q;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_VALUE: raddr = ADDR_W'(v_ext - CMP_W'(1));
			RD_WALK:  raddr = ADDR_W'(p_q - VW'(1));
			default:  raddr = ADDR_W'(item_ext - CMP_W'(1));
		endcase
	end

	assign we    = cmd.clr_en || cmd.check;
	assign waddr = cmd.clr_en ? clr_addr_q : ADDR_W'(v_ext - CMP_W'(1));
	assign wdata = cmd.clr_en ? '0 : epoch_q;

	// map entry holds the tag of the sequence that saw it; stale tags read as unseen
	rkl_ram #(
		.WIDTH(EPOCH_W),
		.DEPTH(MAX_VALUE)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_rank_q       <= K_W'(1);
			kth_q          <= '0;
			count_q        <= '0;
			epoch_q        <= EPOCH_W'(1);
			clr_addr_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (k_rank_we) begin
				k_rank_q <= k_rank;
			end
			if (cmd.accept && restart) begin
				kth_q   <= '0;
				count_q <= '0;
				if (!(&epoch_q)) begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end else begin
				kth_q   <= kth_d;
				count_q <= count_d;
			end
			if (cmd.clr_en) begin
				if (sts.clr_last) begin
					clr_addr_q <= '0;
					epoch_q    <= EPOCH_W'(1);
				end else begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
				end
			end
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q <= value;
			k_q <= k_eff;
		end
		if (cmd.check) begin
			p_q <= kth_q + VW'(1);
		end else if (cmd.walk_step) begin
			p_q <= p_q + VW'(1);
		end
		if (cmd.load_out) begin
			kth_out_q   <= VALUE_W'(kth_d);
			count_out_q <= COUNT_W'(count_d);
		end
	end

	assign result_valid = result_valid_q;
	assign kth_largest  = kth_out_q;
	assign items_seen   = count_out_q;

endmodule
